FILE: rtl/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared widths, reset values and codes of the servo PWM sweep generator.
// ----------------------------------------------------------------------------
package spwm_pkg;

  localparam int ANGLE_W = 8;
  localparam int SPAN_W  = 12;
  localparam int TICK_W  = 16;
  localparam int PPS_W   = 8;
  localparam int PROD_W  = ANGLE_W + SPAN_W;

  localparam int DEFAULT_MAX_ANGLE = 180;

  localparam logic [TICK_W-1:0] PERIOD_RST    = 16'd20000;
  localparam logic [TICK_W-1:0] MIN_PULSE_RST = 16'd500;
  localparam logic [SPAN_W-1:0] SPAN_RST      = 12'd1900;
  localparam logic [PPS_W-1:0]  PPS_RST       = 8'd50;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_MIN_PULSE = 2'd1,
    CFG_SPAN      = 2'd2,
    CFG_PPS       = 2'd3
  } cfg_idx_t;

  // Input item kinds carried on in_tuser.
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_MOVE = 1'b1
  } func_t;

endpackage

FILE: rtl/spwm_width.sv
// ----------------------------------------------------------------------------
// spwm_width
// High time of one period: min_pulse + angle*span/MAX_ANGLE, saturated at the
// period. The angle*span product arrives registered; the division by the
// constant angle range is an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module spwm_width
  import spwm_pkg::*;
#(
  parameter int MAX_ANGLE = DEFAULT_MAX_ANGLE
) (
  input  logic [PROD_W-1:0] prod,
  input  logic [TICK_W-1:0] min_pulse,
  input  logic [TICK_W-1:0] period,
  output logic [TICK_W-1:0] high_width
);

  // Shift of dividend width plus divisor width gives an exact floor for
  // every dividend below 2**PROD_W.
  localparam int RECIP_SH = PROD_W + ANGLE_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int MUL_W    = PROD_W + RECIP_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(MAX_ANGLE) - 64'd1) / 64'(MAX_ANGLE));

  logic [MUL_W-1:0]  mul;
  logic [PROD_W-1:0] quot;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    mul  = MUL_W'(prod) * MUL_W'(RECIP);
    quot = mul[RECIP_SH +: PROD_W];
    sum  = SUM_W'(min_pulse) + SUM_W'(quot);
    if (sum > SUM_W'(period)) begin
      high_width = period;
    end else begin
      high_width = sum[TICK_W-1:0];
    end
  end

endmodule

FILE: rtl/servo_pwm_sweep_generator.sv
// ----------------------------------------------------------------------------
// servo_pwm_sweep_generator
// RC servo PWM generator that sweeps one degree at a time from a start angle
// to a target angle, one pin sample per microsecond tick item.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      slave      tuser: func; tdata: start_angle[7:0], target_angle[15:8]
//  out_     master     tdata: pin_level, angle_now, busy_res, command_rejected
//  cfg_     slave      cfg_index selects the register, cfg_data its value
//
//  One item per cycle unless stalled; each result is registered and shows
//  in the cycle after its item is taken. The output register frees up in
//  the cycle it is read, so in_tready only drops while a result is held by
//  a low out_tready. Reset clears the sweep state and loads the default
//  timing registers. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module servo_pwm_sweep_generator
  import spwm_pkg::*;
#(
  parameter int MAX_ANGLE = DEFAULT_MAX_ANGLE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // start_angle[7:0], target_angle[15:8]
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pin_level[0], angle_now[8:1], busy_res[9],
                                  // command_rejected[10], zero fill [15:11]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(MAX_ANGLE);

  // Configuration.
  logic [TICK_W-1:0] period_r,    period_nxt;
  logic [TICK_W-1:0] min_pulse_r, min_pulse_nxt;
  logic [SPAN_W-1:0] span_r,      span_nxt;
  logic [PPS_W-1:0]  pps_r,       pps_nxt;

  // Sweep state.
  logic [TICK_W-1:0]  tick_r,   tick_nxt;
  logic [PPS_W-1:0]   pcount_r, pcount_nxt;
  logic [ANGLE_W-1:0] angle_r,  angle_nxt;
  logic [ANGLE_W-1:0] goal_r,   goal_nxt;
  logic [PROD_W-1:0]  prod_r,   prod_nxt;
  logic [TICK_W-1:0]  hw_min_r, hw_min_nxt;
  logic [TICK_W-1:0]  hw_per_r, hw_per_nxt;
  logic               moving_r, moving_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               pin_r,       pin_nxt;
  logic [ANGLE_W-1:0] shown_r,     shown_nxt;
  logic               reject_r,    reject_nxt;

  logic               in_acc;
  func_t              func;
  logic [ANGLE_W-1:0] start_cl;
  logic [ANGLE_W-1:0] target_cl;
  logic [TICK_W-1:0]  high_width;
  logic [TICK_W:0]    tick_inc;
  logic [PPS_W-1:0]   pcount_inc;
  logic               load_prod;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign func       = func_t'(in_tuser);
  assign start_cl   = (in_tdata[7:0] > ANGLE_MAX) ? ANGLE_MAX : in_tdata[7:0];
  assign target_cl  = (in_tdata[15:8] > ANGLE_MAX) ? ANGLE_MAX : in_tdata[15:8];
  assign tick_inc   = (TICK_W+1)'(tick_r) + (TICK_W+1)'(1);
  assign pcount_inc = pcount_r + PPS_W'(1);

  spwm_width #(
    .MAX_ANGLE (MAX_ANGLE)
  ) u_width (
    .prod       (prod_r),
    .min_pulse  (hw_min_r),
    .period     (hw_per_r),
    .high_width (high_width)
  );

  // Configuration decode.
  always_comb begin
    period_nxt    = period_r;
    min_pulse_nxt = min_pulse_r;
    span_nxt      = span_r;
    pps_nxt       = pps_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PERIOD:    period_nxt    = cfg_data;
        CFG_MIN_PULSE: min_pulse_nxt = cfg_data;
        CFG_SPAN:      span_nxt      = cfg_data[SPAN_W-1:0];
        CFG_PPS:       pps_nxt       = cfg_data[PPS_W-1:0];
        default:       period_nxt    = period_r;
      endcase
    end
  end

  // Sweep state and result for one accepted item.
  always_comb begin
    tick_nxt      = tick_r;
    pcount_nxt    = pcount_r;
    angle_nxt     = angle_r;
    goal_nxt      = goal_r;
    moving_nxt    = moving_r;
    load_prod     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    pin_nxt       = pin_r;
    shown_nxt     = shown_r;
    reject_nxt    = reject_r;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      pin_nxt       = 1'b0;
      reject_nxt    = 1'b0;
      shown_nxt     = angle_r;
      if (func == FUNC_MOVE) begin
        if (moving_r) begin
          reject_nxt = 1'b1;
        end else begin
          angle_nxt  = start_cl;
          goal_nxt   = target_cl;
          tick_nxt   = '0;
          pcount_nxt = '0;
          moving_nxt = 1'b1;
          load_prod  = 1'b1;
          shown_nxt  = start_cl;
        end
      end else if (moving_r) begin
        pin_nxt = (tick_r < high_width);
        if (tick_inc >= (TICK_W+1)'(period_r)) begin
          tick_nxt   = '0;
          pcount_nxt = pcount_inc;
          if (pcount_inc >= pps_r) begin
            pcount_nxt = '0;
            if (angle_r == goal_r) begin
              moving_nxt = 1'b0;
            end else begin
              load_prod = 1'b1;
              if (angle_r < goal_r) begin
                angle_nxt = angle_r + ANGLE_W'(1);
              end else begin
                angle_nxt = angle_r - ANGLE_W'(1);
              end
            end
          end
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
    end

    // The product of the new angle is registered so the width path starts
    // from a flop. The timing registers that shape the width are captured
    // with it, so later writes leave the width alone until the next load.
    if (load_prod) begin
      prod_nxt   = PROD_W'(angle_nxt) * PROD_W'(span_r);
      hw_min_nxt = min_pulse_r;
      hw_per_nxt = period_r;
    end else begin
      prod_nxt   = prod_r;
      hw_min_nxt = hw_min_r;
      hw_per_nxt = hw_per_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      min_pulse_r <= MIN_PULSE_RST;
      span_r      <= SPAN_RST;
      pps_r       <= PPS_RST;
      tick_r      <= '0;
      pcount_r    <= '0;
      angle_r     <= '0;
      goal_r      <= '0;
      prod_r      <= '0;
      hw_min_r    <= '0;
      hw_per_r    <= '0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      min_pulse_r <= min_pulse_nxt;
      span_r      <= span_nxt;
      pps_r       <= pps_nxt;
      tick_r      <= tick_nxt;
      pcount_r    <= pcount_nxt;
      angle_r     <= angle_nxt;
      goal_r      <= goal_nxt;
      prod_r      <= prod_nxt;
      hw_min_r    <= hw_min_nxt;
      hw_per_r    <= hw_per_nxt;
      moving_r    <= moving_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pin_r    <= pin_nxt;
    shown_r  <= shown_nxt;
    reject_r <= reject_nxt;
  end

  // busy_res reflects the state after the item, which is moving_r once the
  // result is registered; it is captured with the result so a stall holds it.
  logic busy_r, busy_nxt;

  assign busy_nxt = in_acc ? moving_nxt : busy_r;

  always_ff @(posedge clk) begin
    busy_r <= busy_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, reject_r, busy_r, shown_r, pin_r};

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo PWM sweep generator. Move commands and
// microsecond ticks stream in with random idle bursts on both sides, while
// the timing registers are rewritten between batches. An item-by-item
// prediction of the pin level, angle and status flags is checked against
// every result.
// ----------------------------------------------------------------------------
module tb;
  import spwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEG     = DEFAULT_MAX_ANGLE;
  localparam int BATCH_ITEMS = 56;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic       pin;
    logic [7:0] angle;
    logic       busy;
    logic       rej;
  } servo_res_t;

  typedef struct {
    func_t       fn;
    logic [15:0] data;
  } servo_item_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_tvalid    = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata     = '0;
  logic        in_tuser     = 1'b0;
  logic        out_tvalid;
  logic        out_tready   = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;

  servo_pwm_sweep_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Register copies and sweep state of the predictor.
  logic [15:0] per_len         = PERIOD_RST;
  logic [15:0] min_pulse       = MIN_PULSE_RST;
  logic [11:0] span_len        = SPAN_RST;
  logic [7:0]  steps_per_angle = PPS_RST;
  logic [15:0] tick_pos        = '0;
  logic [7:0]  periods_done    = '0;
  logic [7:0]  cur_angle       = '0;
  logic [7:0]  goal            = '0;
  logic [15:0] hi_width        = '0;
  logic        sweeping        = 1'b0;

  servo_item_t cmd_backlog[$];
  servo_res_t  pin_samples_due[$];
  servo_item_t nxt_item;
  servo_res_t  want;

  logic in_acc  = 1'b0;
  logic cfg_acc = 1'b0;
  int   in_gap, out_gap;
  int   in_idle_pct, out_idle_pct;
  int   n_queued, n_checked, n_errors, stall_cycles;

  function automatic logic [7:0] clamp_deg(logic [7:0] a);
    return (int'(a) > MAX_DEG) ? 8'(MAX_DEG) : a;
  endfunction

  function automatic logic [15:0] pulse_width(logic [7:0] deg);
    int w;
    w = int'(min_pulse) + (int'(deg) * int'(span_len)) / MAX_DEG;
    return (w > int'(per_len)) ? per_len : w[15:0];
  endfunction

  function automatic servo_res_t next_pin_sample(func_t fn, logic [7:0] a0,
                                                 logic [7:0] a1);
    servo_res_t r;
    int nxt;
    r = '0;
    if (fn == FUNC_MOVE) begin
      if (sweeping) begin
        r.rej = 1'b1;
      end else begin
        cur_angle    = clamp_deg(a0);
        goal         = clamp_deg(a1);
        tick_pos     = '0;
        periods_done = '0;
        hi_width     = pulse_width(cur_angle);
        sweeping     = 1'b1;
      end
    end else if (sweeping) begin
      r.pin = tick_pos < hi_width;
      nxt = int'(tick_pos) + 1;
      // A zero period or a zero step count behaves like one.
      if (nxt >= int'(per_len)) begin
        tick_pos     = '0;
        periods_done = periods_done + 8'd1;
        if (periods_done >= steps_per_angle) begin
          periods_done = '0;
          if (cur_angle == goal) begin
            sweeping = 1'b0;
          end else begin
            cur_angle = (cur_angle < goal) ? cur_angle + 8'd1 : cur_angle - 8'd1;
            hi_width  = pulse_width(cur_angle);
          end
        end
      end else begin
        tick_pos = nxt[15:0];
      end
    end
    // The angle shown is the one driven before any step of this tick.
    r.angle = (fn == FUNC_MOVE) ? cur_angle : r.angle;
    r.busy  = sweeping;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
    $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    n_errors++;
  endtask

  // The angle field of a tick result must be taken before the step, so the
  // monitor records it ahead of the prediction.
  always @(posedge clk) begin
    in_acc  <= in_tvalid && in_tready;
    cfg_acc <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PERIOD:    per_len = cfg_data;
          CFG_MIN_PULSE: min_pulse = cfg_data;
          CFG_SPAN:      span_len = cfg_data[11:0];
          CFG_PPS:       steps_per_angle = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = '0;
        want.angle = cur_angle;
        want = next_pin_sample(func_t'(in_tuser), in_tdata[7:0], in_tdata[15:8])
               | ((func_t'(in_tuser) == FUNC_MOVE) ? '0 : want);
        pin_samples_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (pin_samples_due.size() == 0) begin
          flag_mismatch("result with nothing pending", out_tdata, '0);
        end else begin
          want = pin_samples_due.pop_front();
          n_checked++;
          if (out_tdata[0] !== want.pin)
            flag_mismatch("pin_level", 16'(out_tdata[0]), 16'(want.pin));
          if (out_tdata[8:1] !== want.angle)
            flag_mismatch("angle_now", 16'(out_tdata[8:1]), 16'(want.angle));
          if (out_tdata[9] !== want.busy)
            flag_mismatch("busy_res", 16'(out_tdata[9]), 16'(want.busy));
          if (out_tdata[10] !== want.rej)
            flag_mismatch("command_rejected", 16'(out_tdata[10]), 16'(want.rej));
          if (out_tdata[15:11] !== '0)
            flag_mismatch("zero fill", 16'(out_tdata[15:11]), '0);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // A request stays on the bus until the block takes it; new requests and
  // the result-side stalls come with random idle bursts.
  always @(negedge clk) begin
    if (!in_tvalid || in_acc) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (cmd_backlog.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < in_idle_pct) begin
        in_tvalid <= 1'b0;
        in_gap    <= $urandom_range(0, 16);
      end else begin
        nxt_item  = cmd_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt_item.fn;
        in_tdata  <= nxt_item.data;
      end
    end
    if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_tready <= 1'b0;
      out_gap    <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_item(func_t fn, logic [15:0] data);
    servo_item_t it;
    it.fn   = fn;
    it.data = data;
    cmd_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(FUNC_TICK, 16'($urandom));
  endtask

  // One move followed by about enough ticks to finish it; some are cut
  // short and a few carry a stray command that may land while busy.
  task automatic queue_sweep(int tick_cost);
    logic [7:0] a0, a1;
    int c0, c1, deg_diff, n;
    a0 = 8'($urandom_range(0, 255));
    c0 = int'(clamp_deg(a0));
    if (tick_cost <= 2 && $urandom_range(0, 3) == 0) begin
      a1 = 8'($urandom_range(0, 255));
    end else begin
      c1 = c0 + int'($urandom_range(0, 6)) - 3;
      c1 = (c1 < 0) ? 0 : (c1 > MAX_DEG) ? MAX_DEG : c1;
      a1 = 8'(c1);
      if (c1 == MAX_DEG && $urandom_range(0, 1) == 1)
        a1 = 8'($urandom_range(MAX_DEG, 255));
    end
    c1       = int'(clamp_deg(a1));
    deg_diff = (c1 > c0) ? c1 - c0 : c0 - c1;
    n        = (deg_diff + 1) * tick_cost + int'($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0)
      n = int'($urandom_range(0, n));
    if (n > 60)
      n = 60;
    queue_item(FUNC_MOVE, {a1, a0});
    repeat (n) begin
      if ($urandom_range(0, 29) == 0)
        queue_item(FUNC_MOVE, 16'($urandom));
      else
        queue_item(FUNC_TICK, 16'($urandom));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_acc);
  endtask

  task automatic write_regs(logic [15:0] per, logic [15:0] minp, logic [11:0] span,
                            logic [7:0] pps);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_MIN_PULSE, minp);
    write_reg(CFG_SPAN, {4'd0, span});
    write_reg(CFG_PPS, {8'd0, pps});
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    while (n_checked != n_queued) @(negedge clk);
  endtask

  initial begin
    logic [15:0] per, minp;
    logic [11:0] span;
    logic [7:0]  pps;
    int          cost, mark;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset timing: a tick while idle, then a move that is still running
    // when the registers are rewritten under it.
    @(posedge clk);
    in_idle_pct  = 20;
    out_idle_pct = 20;
    queue_item(FUNC_TICK, 16'hFFFF);
    queue_item(FUNC_MOVE, {8'd10, 8'd10});
    queue_ticks(3);
    settle();

    write_regs(16'd3, 16'd0, 12'hFFF, 8'd1);
    @(posedge clk);
    queue_ticks(2);
    queue_item(FUNC_MOVE, {8'd255, 8'd255});  // both clamp, start equals target
    queue_item(FUNC_MOVE, {8'd255, 8'd0});    // lands while busy
    queue_ticks(3);
    queue_item(FUNC_MOVE, {8'd1, 8'd0});      // one step up
    queue_ticks(6);
    queue_item(FUNC_MOVE, {8'd1, 8'd2});      // one step down
    queue_ticks(6);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          per  = 16'd0;
          minp = 16'($urandom);
          span = 12'($urandom);
          pps  = 8'd0;
        end
        1: begin
          per  = 16'hFFFF;
          minp = 16'hFFFF;
          span = 12'hFFF;
          pps  = 8'hFF;
        end
        2: begin
          per  = 16'd1;
          minp = 16'd0;
          span = 12'd0;
          pps  = 8'd1;
        end
        default: begin
          per  = 16'($urandom_range(1, 8));
          minp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
          span = 12'($urandom);
          pps  = 8'($urandom_range(1, 3));
        end
      endcase
      write_regs(per, minp, span, pps);
      cost = ((per == 0) ? 1 : int'(per)) * ((pps == 0) ? 1 : int'(pps));
      @(posedge clk);
      if (ph == 7) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 10 * int'($urandom_range(0, 3));
        out_idle_pct = 10 * int'($urandom_range(0, 3));
      end
      mark = n_queued;
      while (n_queued - mark < BATCH_ITEMS) queue_sweep(cost);
      settle();
    end

    repeat (20) @(negedge clk);
    if (pin_samples_due.size() != 0)
      flag_mismatch("results never delivered", 16'(pin_samples_due.size()), '0);
    if (n_errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
